// ----- rtl/jbp_pkg.sv -----
// jbp_pkg: shared types and constants for the jpeg bit packer
// controller states, datapath command and status structs
// no dependencies
package jbp_pkg;

    localparam int MAX_FIELD_BITS_DEF = 32;

    localparam logic [7:0] BYTE_FF   = 8'hFF;
    localparam logic [7:0] BYTE_STUF = 8'h00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_EMIT,
        ST_STUFF
    } state_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_FLUSH,
        EMIT_DATA,
        EMIT_STUFF
    } emit_t;

    typedef struct packed {
        logic  load;
        emit_t emit;
        logic  last;
    } cmd_t;

    typedef struct packed {
        logic ld_flush;
        logic ld_bytes_nz;
        logic flush_ff;
        logic top_stuff;
        logic bytes_nz;
        logic bytes_one;
        logic out_free;
    } status_t;

endpackage

// ----- rtl/jbp_ctrl.sv -----
// jbp_ctrl: sequencer for the jpeg bit packer
// walks flush byte, data bytes and stuffing bytes; uses jbp_pkg
module jbp_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  jbp_pkg::status_t status,
    output jbp_pkg::cmd_t    cmd
);

    jbp_pkg::state_t state_reg;
    jbp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= jbp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            jbp_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (status.ld_flush)
                        state_next = jbp_pkg::ST_FLUSH;
                    else if (status.ld_bytes_nz)
                        state_next = jbp_pkg::ST_EMIT;
                end
            end
            jbp_pkg::ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    if (status.flush_ff)
                        state_next = jbp_pkg::ST_STUFF;
                    else if (status.bytes_nz)
                        state_next = jbp_pkg::ST_EMIT;
                    else
                        state_next = jbp_pkg::ST_IDLE;
                end
            end
            jbp_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    if (status.top_stuff)
                        state_next = jbp_pkg::ST_STUFF;
                    else if (status.bytes_one)
                        state_next = jbp_pkg::ST_IDLE;
                end
            end
            jbp_pkg::ST_STUFF:
            begin
                // byte count was already decremented by the data beat
                if (status.out_free)
                begin
                    if (status.bytes_nz)
                        state_next = jbp_pkg::ST_EMIT;
                    else
                        state_next = jbp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = jbp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        cmd.load  = 1'b0;
        cmd.emit  = jbp_pkg::EMIT_NONE;
        cmd.last  = 1'b0;
        case (state_reg)
            jbp_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            jbp_pkg::ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    cmd.emit = jbp_pkg::EMIT_FLUSH;
                    cmd.last = !status.flush_ff && !status.bytes_nz;
                end
            end
            jbp_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = jbp_pkg::EMIT_DATA;
                    cmd.last = !status.top_stuff && status.bytes_one;
                end
            end
            jbp_pkg::ST_STUFF:
            begin
                if (status.out_free)
                begin
                    cmd.emit = jbp_pkg::EMIT_STUFF;
                    cmd.last = !status.bytes_nz;
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // a stalled output freezes the sequencer
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != jbp_pkg::ST_IDLE) && !status.out_free |=> state_reg == $past(state_reg))
        else $error("sequencer moved while output stalled");

    // a beat is only written into a free output slot
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit != jbp_pkg::EMIT_NONE) |-> status.out_free)
        else $error("beat written into occupied output slot");

    // data beats only while whole bytes remain
    a_emit_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == jbp_pkg::ST_EMIT) |-> status.bytes_nz)
        else $error("data state with no bytes left");

endmodule

// ----- rtl/jbp_datapath.sv -----
// jbp_datapath: bit accumulator, pending bits and output register
// driven by jbp_ctrl commands; uses jbp_pkg
module jbp_datapath
#(
    parameter int MAX_FIELD_BITS = jbp_pkg::MAX_FIELD_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             command,
    input  logic [31:0]      bits_value,
    input  logic [5:0]       bit_count,
    input  logic             marker_write,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       out_byte,
    output logic             last_of_run,
    input  jbp_pkg::cmd_t    cmd,
    output jbp_pkg::status_t status
);

    localparam int AW = MAX_FIELD_BITS + 7;
    localparam int CW = $clog2(AW + 1);
    localparam int BW = CW - 3;

    // acc_reg holds the complete bytes of the item, left aligned
    logic [AW-1:0] acc_reg;
    logic [AW-1:0] acc_next;
    logic [BW-1:0] bytes_reg;
    logic [BW-1:0] bytes_next;
    logic          marker_reg;
    logic [7:0]    flush_byte_reg;
    logic [6:0]    pend_bits_reg;
    logic [6:0]    pend_bits_next;
    logic [2:0]    pend_cnt_reg;
    logic [2:0]    pend_cnt_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [7:0]    out_byte_reg;
    logic [7:0]    out_byte_next;
    logic          out_last_reg;

    logic [5:0]    count_c;
    logic [31:0]   val_masked;
    logic [6:0]    eff_pb;
    logic [2:0]    eff_pc;
    logic [AW-1:0] combined;
    logic [CW-1:0] cnt_total;
    logic [CW-1:0] align_sh;
    logic [7:0]    flush_byte;
    logic          is_flush;
    logic [7:0]    top_byte;

    always_comb
    begin
        is_flush   = command;
        count_c    = (bit_count > 6'(MAX_FIELD_BITS)) ? 6'(MAX_FIELD_BITS) : bit_count;
        val_masked = bits_value & ~(32'hFFFF_FFFF << count_c);
        // a marker write drops the pending bits after flushing them
        eff_pb     = marker_write ? 7'd0 : pend_bits_reg;
        eff_pc     = marker_write ? 3'd0 : pend_cnt_reg;
        combined   = (AW'(eff_pb) << count_c) | AW'(val_masked[MAX_FIELD_BITS-1:0]);
        cnt_total  = is_flush ? CW'(0) : CW'(eff_pc) + CW'(count_c);
        align_sh   = CW'(AW) - cnt_total;
        flush_byte = 8'({1'b0, pend_bits_reg} << (4'd8 - {1'b0, pend_cnt_reg}));
        top_byte   = acc_reg[AW-1 -: 8];
    end

    always_comb
    begin
        acc_next       = acc_reg;
        bytes_next     = bytes_reg;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        if (cmd.load)
        begin
            acc_next   = combined << align_sh;
            bytes_next = BW'(cnt_total >> 3);
            if (is_flush)
            begin
                pend_bits_next = 7'd0;
                pend_cnt_next  = 3'd0;
            end
            else
            begin
                pend_bits_next = combined[6:0] & ~(7'h7F << cnt_total[2:0]);
                pend_cnt_next  = cnt_total[2:0];
            end
        end
        else if (cmd.emit == jbp_pkg::EMIT_DATA)
        begin
            acc_next   = acc_reg << 8;
            bytes_next = bytes_reg - BW'(1);
        end
    end

    always_comb
    begin
        out_byte_next  = out_byte_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (cmd.emit)
            jbp_pkg::EMIT_FLUSH:
            begin
                out_byte_next  = flush_byte_reg;
                out_valid_next = 1'b1;
            end
            jbp_pkg::EMIT_DATA:
            begin
                out_byte_next  = top_byte;
                out_valid_next = 1'b1;
            end
            jbp_pkg::EMIT_STUFF:
            begin
                out_byte_next  = jbp_pkg::BYTE_STUF;
                out_valid_next = 1'b1;
            end
            default:
            begin
                out_byte_next = out_byte_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_bits_reg <= 7'd0;
            pend_cnt_reg  <= 3'd0;
            bytes_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            bytes_reg     <= bytes_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        out_byte_reg <= out_byte_next;
        if (cmd.load)
        begin
            marker_reg     <= marker_write && !is_flush;
            flush_byte_reg <= flush_byte;
        end
        if (cmd.emit != jbp_pkg::EMIT_NONE)
        begin
            out_last_reg <= cmd.last;
        end
    end

    always_comb
    begin
        status.ld_flush    = (is_flush || marker_write) && (pend_cnt_reg != 3'd0);
        status.ld_bytes_nz = (cnt_total >> 3) != CW'(0);
        status.flush_ff    = flush_byte_reg == jbp_pkg::BYTE_FF;
        status.top_stuff   = !marker_reg && (top_byte == jbp_pkg::BYTE_FF);
        status.bytes_nz    = bytes_reg != BW'(0);
        status.bytes_one   = bytes_reg == BW'(1);
        status.out_free    = !out_valid_reg || m_tready;
    end

    assign m_tvalid    = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = out_last_reg;

    // zero padding never yields a byte that needs stuffing
    a_pad_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit == jbp_pkg::EMIT_FLUSH) |-> !status.flush_ff)
        else $error("padded flush byte is 0xff");

endmodule

// ----- rtl/jpeg_bit_packer_byte_stuffing_unit.sv -----
// jpeg_bit_packer_byte_stuffing_unit: top level of the jpeg entropy bit packer
// instantiates jbp_ctrl and jbp_datapath; uses jbp_pkg
//
// usage:
//   slave channel s_*: one beat per command. tuser selects write bits (0)
//   or flush partial byte (1) and flags a marker write; tdata carries the
//   code bits and their count. write beats append bits msb first to up to
//   seven pending bits; each completed byte goes out on the master channel,
//   a 0xff data byte is followed by a 0x00 stuffing byte. a marker write
//   first flushes the partial byte and its own bytes go out unstuffed.
//   master channel m_*: one output byte per beat, tlast on the final byte
//   caused by an input beat. a beat that completes no byte gives no output.
//   timing: a beat is taken while the sequencer is idle, then its bytes
//   leave one per cycle while the receiver is ready, the first byte
//   passing the state register and then the output register.
//   the byte sequencer is the limit; s_tready is high only between items.
//   a stalled receiver holds the output register and the sequencer;
//   the next input beat is still taken while the last byte waits.
//   reset clears the pending bits and drops any output beat.
module jpeg_bit_packer_byte_stuffing_unit
#(
    parameter int MAX_FIELD_BITS = jbp_pkg::MAX_FIELD_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] bits_value, [37:32] bit_count, [39:38] zero
    input  logic [1:0]  s_tuser,   // [0] command, [1] marker_write
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast
);

    jbp_pkg::cmd_t    cmd;
    jbp_pkg::status_t status;

    jbp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    jbp_datapath
    #(
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .command      (s_tuser[0]),
        .bits_value   (s_tdata[31:0]),
        .bit_count    (s_tdata[37:32]),
        .marker_write (s_tuser[1]),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .out_byte     (m_tdata),
        .last_of_run  (m_tlast),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// tb: self-checking testbench for jpeg_bit_packer_byte_stuffing_unit
// predicts the packed and stuffed byte stream per input beat and checks every output beat
// depends on jbp_pkg and the rtl top level only

typedef struct {
    bit [7:0] data;
    bit       last;
} out_beat_t;

class stuffed_stream_checker;
    out_beat_t   expected_bytes[$];
    bit [6:0]    held_bits;
    int unsigned held_count;
    int unsigned errors;
    int unsigned beats_seen;

    function void push_data_byte(bit [7:0] b, bit stuff);
        out_beat_t ob;
        ob.data = b;
        ob.last = 1'b0;
        expected_bytes.push_back(ob);
        // a 0xff data byte is followed by a zero byte unless it belongs to a marker
        if (stuff && b == jbp_pkg::BYTE_FF)
        begin
            ob.data = jbp_pkg::BYTE_STUF;
            expected_bytes.push_back(ob);
        end
    endfunction

    function void drain_partial();
        bit [7:0] b;
        if (held_count != 0)
        begin
            b = {1'b0, held_bits} << (8 - held_count);
            push_data_byte(b, 1'b1);
        end
        held_bits  = '0;
        held_count = 0;
    endfunction

    function void note_command(bit cmd, bit [31:0] value, bit [5:0] count, bit marker);
        int unsigned first;
        int unsigned width;
        int unsigned cnt;
        bit [63:0]   acc;
        bit [63:0]   mask;
        first = expected_bytes.size();
        if (cmd)
            drain_partial();
        else
        begin
            if (marker)
                drain_partial();
            width = (count > jbp_pkg::MAX_FIELD_BITS_DEF) ? jbp_pkg::MAX_FIELD_BITS_DEF : count;
            mask  = (64'd1 << width) - 64'd1;
            acc   = ({57'd0, held_bits} << width) | ({32'd0, value} & mask);
            cnt   = held_count + width;
            while (cnt >= 8)
            begin
                push_data_byte(8'(acc >> (cnt - 8)), !marker);
                cnt -= 8;
            end
            held_bits  = 7'(acc & ((64'd1 << cnt) - 64'd1));
            held_count = cnt;
        end
        if (expected_bytes.size() > first)
            expected_bytes[expected_bytes.size() - 1].last = 1'b1;
    endfunction

    function void check_byte(bit [7:0] data, bit last);
        out_beat_t ob;
        beats_seen++;
        if (expected_bytes.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("beat %0d: unexpected byte %02h last %0b, nothing pending",
                         beats_seen, data, last);
            return;
        end
        ob = expected_bytes.pop_front();
        if (ob.data !== data || ob.last !== last)
        begin
            errors++;
            if (errors <= 10)
                $display("beat %0d: expected byte %02h last %0b, got byte %02h last %0b",
                         beats_seen, ob.data, ob.last, data, last);
        end
    endfunction
endclass

module tb;

    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 3000;
    localparam int RANDOM_ITEMS  = 260;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // [31:0] bits_value, [37:32] bit_count, [39:38] zero
    logic [1:0]  s_tuser;   // [0] command, [1] marker_write
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] out_byte
    logic        m_tlast;

    stuffed_stream_checker sb;
    int unsigned           burst_left;
    int unsigned           idle_cycles;
    bit                    long_hold_req;

    jpeg_bit_packer_byte_stuffing_unit i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // beats on both channels, inputs noted before outputs are checked
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (s_tvalid && s_tready)
                sb.note_command(s_tuser[0], s_tdata[31:0], s_tdata[37:32], s_tuser[1]);
            if (m_tvalid && m_tready)
                sb.check_byte(m_tdata, m_tlast);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("no beat accepted for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // receiver: stretches of varying back-pressure, plus one long hold-off on request
    initial
    begin
        int mode;
        int span;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    @(negedge clk);
                    m_tready = 1'b0;
                end
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 60);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0:       m_tready = 1'b1;
                    1:       m_tready = ($urandom_range(0, 3) != 0);
                    2:       m_tready = ~m_tready;
                    default: m_tready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_item(input bit cmd, input bit [31:0] val, input bit [5:0] cnt,
                             input bit mk);
        if (burst_left == 0)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 11)) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
        @(negedge clk);
        s_tdata  = {2'b00, cnt, val};
        s_tuser  = {mk, cmd};
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        burst_left--;
    endtask

    task automatic send_random_item();
        int        sel;
        bit        cmd;
        bit        mk;
        bit [31:0] val;
        bit [5:0]  cnt;
        sel = $urandom_range(0, 99);
        cmd = (sel < 8);
        mk  = (sel >= 8 && sel < 15);
        case ($urandom_range(0, 9))
            0:       cnt = 6'd0;
            1:       cnt = 6'($urandom_range(33, 63));
            2, 3, 4: cnt = 6'($urandom_range(1, 8));
            5, 6:    cnt = 6'($urandom_range(9, 16));
            default: cnt = 6'($urandom_range(17, 32));
        endcase
        val = $urandom;
        case ($urandom_range(0, 5))
            0: val = 32'hFFFF_FFFF;
            1: val = val | 32'hFF00_FF00;
            default: ;
        endcase
        // typical marker: 0xff followed by a code byte
        if (mk && $urandom_range(0, 1) == 1)
        begin
            cnt = 6'd16;
            val = {16'h0000, 8'hFF, 8'($urandom)};
        end
        send_item(cmd, val, cnt, mk);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        burst_left    = 0;
        idle_cycles   = 0;
        long_hold_req = 1'b0;
        sb            = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part
        send_item(1'b0, 32'hFFFF_FFFF, 6'd0, 1'b0);    // zero count, nothing out
        send_item(1'b0, 32'hFFFF_FFFF, 6'd32, 1'b0);   // four stuffed 0xff bytes
        send_item(1'b0, 32'h0000_007F, 6'd7, 1'b0);
        send_item(1'b0, 32'h0000_0000, 6'd32, 1'b0);
        send_item(1'b1, 32'h0000_0000, 6'd0, 1'b0);    // flush seven zero bits
        send_item(1'b1, 32'hFFFF_FFFF, 6'd63, 1'b1);   // aligned flush, fields ignored
        send_item(1'b0, 32'h0000_0005, 6'd3, 1'b0);
        send_item(1'b0, 32'h0000_FFD8, 6'd16, 1'b1);   // marker after partial byte
        send_item(1'b0, 32'h0000_0123, 6'd0, 1'b1);    // aligned marker of zero bits
        send_item(1'b0, 32'h0000_001F, 6'd5, 1'b0);
        send_item(1'b0, 32'h0000_0000, 6'd0, 1'b1);    // marker that only flushes
        send_item(1'b0, 32'hFFFF_FFFF, 6'd33, 1'b0);   // oversized count
        send_item(1'b0, 32'hA5A5_A5A5, 6'd63, 1'b0);
        repeat (8)
            send_item(1'b0, 32'hFFFF_FFFF, 6'd1, 1'b0); // 0xff built one bit at a time
        send_item(1'b0, 32'h0000_00FF, 6'd8, 1'b0);
        send_item(1'b0, 32'h0000_000F, 6'd4, 1'b0);
        send_item(1'b1, 32'h5A5A_5A5A, 6'd21, 1'b0);
        send_item(1'b0, 32'h0000_0000, 6'd1, 1'b0);
        send_item(1'b1, 32'h0000_0000, 6'd0, 1'b0);

        // random part; the receiver holds off for a long stretch early on
        long_hold_req = 1'b1;
        repeat (RANDOM_ITEMS)
            send_random_item();
        send_item(1'b1, 32'h0000_0000, 6'd0, 1'b0);
        @(negedge clk);
        s_tvalid = 1'b0;

        while (sb.expected_bytes.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        if (sb.errors == 0 && sb.expected_bytes.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/jbp_pkg.sv
rtl/jbp_ctrl.sv
rtl/jbp_datapath.sv
rtl/jpeg_bit_packer_byte_stuffing_unit.sv
dv/tb.sv
